// File: rtl/assert_macros.svh
// Assertion macros shared by the formatter RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, prop)
`endif
`endif

// File: rtl/fsp_pkg.sv
// Shared types, constants and character tables of the format string printer.
// No dependencies; imported by every module of the block.
package fsp_pkg;

   localparam int DIGIT_DEPTH = 16;
   localparam int DEPTH_W     = $clog2(DIGIT_DEPTH + 1);
   localparam int IDX_W       = $clog2(DIGIT_DEPTH);
   localparam int NULL_LEN    = 6;
   localparam int NULL_W      = $clog2(NULL_LEN);
   localparam int COUNT_W     = 31;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [31:0]        RECIP_TEN = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;

   localparam logic [1:0] KIND_FORMAT = 2'd0;
   localparam logic [1:0] KIND_ARG    = 2'd1;
   localparam logic [1:0] KIND_STRING = 2'd2;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_SPEC_C  = 8'h63;
   localparam logic [7:0] CH_SPEC_D  = 8'h64;
   localparam logic [7:0] CH_SPEC_I  = 8'h69;
   localparam logic [7:0] CH_SPEC_U  = 8'h75;
   localparam logic [7:0] CH_SPEC_X  = 8'h78;
   localparam logic [7:0] CH_SPEC_UX = 8'h58;
   localparam logic [7:0] CH_SPEC_P  = 8'h70;
   localparam logic [7:0] CH_SPEC_S  = 8'h73;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_in;
      logic [63:0] arg_value;
      logic        null_string;
   } req_type;

   typedef struct packed {
      logic [7:0]         char_out;
      logic               last_char;
      logic [COUNT_W-1:0] emitted_count;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_ARMED,
      MODE_WAIT_ARG,
      MODE_STRING
   } mode_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_ONE,
      SEQ_NULL,
      SEQ_CONVERT,
      SEQ_PREFIX,
      SEQ_DIGITS
   } seq_state_type;

   typedef struct packed {
      logic load;
      logic hex;
      logic pop;
   } digit_ctrl_type;

   typedef struct packed {
      logic       converting;
      logic       last;
      logic [3:0] top_digit;
   } digit_status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] digit, input logic upper);
      logic [7:0] c;
      if (digit < 4'd10) begin
         c = CH_ZERO + {4'd0, digit};
      end else if (upper) begin
         c = 8'h41 + {4'd0, digit - 4'd10};
      end else begin
         c = 8'h61 + {4'd0, digit - 4'd10};
      end
      return c;
   endfunction

   function automatic logic [7:0] null_char(input logic [NULL_W-1:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h28;
         3'd1:    c = 8'h6E;
         3'd2:    c = 8'h75;
         3'd3:    c = 8'h6C;
         3'd4:    c = 8'h6C;
         3'd5:    c = 8'h29;
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   function automatic logic is_arg_spec(input logic [7:0] b);
      return (b == CH_SPEC_C) || (b == CH_SPEC_D) || (b == CH_SPEC_I) ||
             (b == CH_SPEC_U) || (b == CH_SPEC_X) || (b == CH_SPEC_UX) ||
             (b == CH_SPEC_P);
   endfunction

endpackage

// File: rtl/fsp_digit_unit.sv
// Shared binary-to-text unit: one decimal or hex digit per cycle into a digit stack.
// Depends on fsp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fsp_digit_unit
   import fsp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  digit_ctrl_type   ctrl,
   input  logic [63:0]      load_value,
   output digit_status_type status
);

   logic [63:0]        value_ff, value_in;
   logic               hex_ff;
   logic               converting_ff;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [3:0]         stack_ff [DIGIT_DEPTH];

   logic [63:0]        product;
   logic [31:0]        quot_dec;
   logic [31:0]        quot_ten;
   logic [31:0]        rem_dec;
   logic [3:0]         digit;
   logic [DEPTH_W-1:0] top_idx;

   // Division by ten uses the exact reciprocal for 32-bit operands.
   always_comb begin
      product  = {32'd0, value_ff[31:0]} * {32'd0, RECIP_TEN};
      quot_dec = 32'(product[63:RECIP_SHIFT]);
      quot_ten = (quot_dec << 3) + (quot_dec << 1);
      rem_dec  = value_ff[31:0] - quot_ten;
      if (hex_ff) begin
         value_in = value_ff >> 4;
         digit    = value_ff[3:0];
      end else begin
         value_in = {32'd0, quot_dec};
         digit    = rem_dec[3:0];
      end
   end

   always_comb begin
      depth_in = depth_ff;
      if (ctrl.load) begin
         depth_in = '0;
      end else if (converting_ff) begin
         depth_in = depth_ff + DEPTH_W'(1);
      end else if (ctrl.pop) begin
         depth_in = depth_ff - DEPTH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         converting_ff <= 1'b0;
         depth_ff      <= '0;
      end else begin
         depth_ff <= depth_in;
         if (ctrl.load) begin
            converting_ff <= 1'b1;
         end else if (converting_ff && (value_in == 64'd0)) begin
            converting_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         value_ff <= load_value;
         hex_ff   <= ctrl.hex;
      end else if (converting_ff) begin
         value_ff <= value_in;
      end
      if (converting_ff && !ctrl.load) begin
         stack_ff[depth_ff[IDX_W-1:0]] <= digit;
      end
   end

   assign top_idx           = depth_ff - DEPTH_W'(1);
   assign status.converting = converting_ff;
   assign status.last       = (depth_ff == DEPTH_W'(1));
   assign status.top_digit  = stack_ff[top_idx[IDX_W-1:0]];

   `ASSERT_CLK(depth_bound_a, clock, reset, depth_ff <= DEPTH_W'(DIGIT_DEPTH))
   `ASSERT_NEVER(pop_invalid_a, clock, reset, ctrl.pop && (converting_ff || depth_ff == '0))
   `ASSERT_CLK(load_starts_a, clock, reset, ctrl.load |=> converting_ff && depth_ff == '0)

endmodule

// File: rtl/format_string_printer_core.sv
// Top level of the format string printer: input decode, output sequencer, result register.
// Depends on fsp_pkg and fsp_digit_unit.
//
// Usage:
// The req channel carries one transaction per format byte, argument word or
// string byte (kind selects which). The rsp channel carries one transaction per
// output character, with last_char set on the final character caused by a
// request and the saturating running character count.
// req_ready is high only while the sequencer is idle; a request is decoded in
// the cycle it is accepted. A plain byte, '%%', 'c' or string byte emits one
// character. A numeric argument first runs the shared digit unit, one digit
// per cycle (up to 10 decimal or 16 hex digits), then emits an optional
// prefix and the digits, one per cycle while the receiver accepts them.
// Requests that produce no characters return req_ready on the next cycle.
// A single output register holds the current rsp transaction; while the
// receiver stalls the sequencer waits, and a new request may be accepted as
// soon as the last character of the previous one sits in that register.
// Synchronous reset returns to plain-text parsing with a zero count.
module format_string_printer_core
   import fsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   seq_state_type      state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [7:0]         spec_ff, spec_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         one_char_ff, one_char_in;
   logic               upper_ff, upper_in;
   logic               pfx_minus_ff, pfx_minus_in;
   logic               pfx_hex_ff, pfx_hex_in;
   logic               pfx_pos_ff, pfx_pos_in;
   logic [NULL_W-1:0]  null_idx_ff, null_idx_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               accept;
   logic               slot_free;
   logic               emit_valid;
   logic               emit_fire;
   logic [7:0]         emit_char;
   logic               emit_last;
   logic [31:0]        arg_low;
   logic [COUNT_W-1:0] count_next;
   digit_ctrl_type     dctrl;
   digit_status_type   dstat;
   logic [63:0]        load_value;

   assign req_ready = (state_ff == SEQ_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit_fire = emit_valid && slot_free;
   assign arg_low   = req_data.arg_value[31:0];

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      spec_in      = spec_ff;
      count_in     = count_ff;
      one_char_in  = one_char_ff;
      upper_in     = upper_ff;
      pfx_minus_in = pfx_minus_ff;
      pfx_hex_in   = pfx_hex_ff;
      pfx_pos_in   = pfx_pos_ff;
      null_idx_in  = null_idx_ff;
      dctrl        = '0;
      load_value   = 64'd0;
      count_next   = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);
      if (emit_fire) begin
         count_in = count_next;
      end
      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  KIND_FORMAT: begin
                     if (mode_ff == MODE_IDLE) begin
                        if (req_data.byte_in == CH_NUL) begin
                           count_in = '0;
                        end else if (req_data.byte_in == CH_PERCENT) begin
                           mode_in = MODE_ARMED;
                        end else begin
                           one_char_in = req_data.byte_in;
                           state_in    = SEQ_ONE;
                        end
                     end else if (mode_ff == MODE_ARMED) begin
                        mode_in = MODE_IDLE;
                        if (req_data.byte_in == CH_NUL) begin
                           count_in = '0;
                        end else if (req_data.byte_in == CH_PERCENT) begin
                           one_char_in = CH_PERCENT;
                           state_in    = SEQ_ONE;
                        end else if (req_data.byte_in == CH_SPEC_S) begin
                           mode_in = MODE_STRING;
                        end else if (is_arg_spec(req_data.byte_in)) begin
                           spec_in = req_data.byte_in;
                           mode_in = MODE_WAIT_ARG;
                        end
                     end
                  end
                  KIND_ARG: begin
                     if (mode_ff == MODE_WAIT_ARG) begin
                        mode_in      = MODE_IDLE;
                        spec_in      = 8'd0;
                        pfx_minus_in = 1'b0;
                        pfx_hex_in   = 1'b0;
                        pfx_pos_in   = 1'b0;
                        upper_in     = 1'b0;
                        load_value   = {32'd0, arg_low};
                        if (spec_ff == CH_SPEC_C) begin
                           one_char_in = req_data.arg_value[7:0];
                           state_in    = SEQ_ONE;
                        end else if (spec_ff == CH_SPEC_D || spec_ff == CH_SPEC_I) begin
                           dctrl.load   = 1'b1;
                           pfx_minus_in = arg_low[31];
                           if (arg_low[31]) begin
                              load_value = {32'd0, 32'd0 - arg_low};
                           end
                           state_in = SEQ_CONVERT;
                        end else if (spec_ff == CH_SPEC_U) begin
                           dctrl.load = 1'b1;
                           state_in   = SEQ_CONVERT;
                        end else if (spec_ff == CH_SPEC_X || spec_ff == CH_SPEC_UX) begin
                           dctrl.load = 1'b1;
                           dctrl.hex  = 1'b1;
                           upper_in   = (spec_ff == CH_SPEC_UX);
                           state_in   = SEQ_CONVERT;
                        end else if (spec_ff == CH_SPEC_P) begin
                           dctrl.load = 1'b1;
                           dctrl.hex  = 1'b1;
                           pfx_hex_in = 1'b1;
                           load_value = req_data.arg_value;
                           state_in   = SEQ_CONVERT;
                        end
                     end
                  end
                  KIND_STRING: begin
                     if (mode_ff == MODE_STRING) begin
                        if (req_data.null_string) begin
                           mode_in     = MODE_IDLE;
                           null_idx_in = '0;
                           state_in    = SEQ_NULL;
                        end else if (req_data.byte_in == CH_NUL) begin
                           mode_in = MODE_IDLE;
                        end else begin
                           one_char_in = req_data.byte_in;
                           state_in    = SEQ_ONE;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         SEQ_ONE: begin
            if (emit_fire) begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_NULL: begin
            if (emit_fire) begin
               if (null_idx_ff == NULL_W'(NULL_LEN - 1)) begin
                  state_in = SEQ_IDLE;
               end else begin
                  null_idx_in = null_idx_ff + NULL_W'(1);
               end
            end
         end
         SEQ_CONVERT: begin
            if (!dstat.converting) begin
               state_in = (pfx_minus_ff || pfx_hex_ff) ? SEQ_PREFIX : SEQ_DIGITS;
            end
         end
         SEQ_PREFIX: begin
            if (emit_fire) begin
               if (pfx_minus_ff || pfx_pos_ff) begin
                  state_in = SEQ_DIGITS;
               end else begin
                  pfx_pos_in = 1'b1;
               end
            end
         end
         SEQ_DIGITS: begin
            if (emit_fire) begin
               dctrl.pop = 1'b1;
               if (dstat.last) begin
                  state_in = SEQ_IDLE;
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      emit_valid = 1'b0;
      emit_char  = CH_NUL;
      emit_last  = 1'b0;
      case (state_ff)
         SEQ_ONE: begin
            emit_valid = 1'b1;
            emit_char  = one_char_ff;
            emit_last  = 1'b1;
         end
         SEQ_NULL: begin
            emit_valid = 1'b1;
            emit_char  = null_char(null_idx_ff);
            emit_last  = (null_idx_ff == NULL_W'(NULL_LEN - 1));
         end
         SEQ_PREFIX: begin
            emit_valid = 1'b1;
            if (pfx_minus_ff) begin
               emit_char = CH_MINUS;
            end else begin
               emit_char = pfx_pos_ff ? CH_LOWER_X : CH_ZERO;
            end
         end
         SEQ_DIGITS: begin
            emit_valid = 1'b1;
            emit_char  = hex_char(dstat.top_digit, upper_ff);
            emit_last  = dstat.last;
         end
         default: begin
         end
      endcase
   end

   fsp_digit_unit u_digit (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (dctrl),
      .load_value (load_value),
      .status     (dstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         mode_ff      <= MODE_IDLE;
         spec_ff      <= 8'd0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         spec_ff  <= spec_in;
         count_ff <= count_in;
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      one_char_ff  <= one_char_in;
      upper_ff     <= upper_in;
      pfx_minus_ff <= pfx_minus_in;
      pfx_hex_ff   <= pfx_hex_in;
      pfx_pos_ff   <= pfx_pos_in;
      null_idx_ff  <= null_idx_in;
      if (emit_fire) begin
         rsp_ff.char_out      <= emit_char;
         rsp_ff.last_char     <= emit_last;
         rsp_ff.emitted_count <= count_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: dv/tb.sv
// Testbench for format_string_printer_core: directed and random format streams,
// checked character by character against a built-in formatter model.
// Depends on fsp_pkg and the RTL of the block.
module tb;
   import fsp_pkg::*;

   localparam logic [1:0]  KIND_UNUSED  = 2'd3;
   localparam logic [47:0] NULL_TEXT    = "(null)";
   localparam int          HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES = 60;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          RANDOM_ITEMS = 50;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   mode_type           parse_state = MODE_IDLE;
   logic [7:0]         pending_conv = CH_NUL;
   logic [COUNT_W-1:0] char_total = '0;
   logic [7:0]         pending_text[$];
   rsp_type            expected_chars[$];

   int mismatches   = 0;
   int cycles       = 0;
   bit idle_on      = 1'b1;
   bit hold_request = 1'b0;
   bit item_taken;

   format_string_printer_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void push_number(input logic [63:0] value, input int base,
                                       input bit upper);
      logic [7:0] digits[$];
      logic [7:0] d;
      do begin
         d = 8'(value % 64'(base));
         if (d < 8'd10) begin
            digits.push_front(CH_ZERO + d);
         end else begin
            digits.push_front((upper ? 8'h41 : 8'h61) + d - 8'd10);
         end
         value = value / 64'(base);
      end while (value != 0);
      foreach (digits[i]) pending_text.push_back(digits[i]);
   endfunction

   function automatic void render_arg(input logic [63:0] arg);
      logic [31:0] low;
      logic [31:0] magnitude;
      low = arg[31:0];
      magnitude = 32'd0 - low;
      case (pending_conv)
         CH_SPEC_C: pending_text.push_back(arg[7:0]);
         CH_SPEC_D, CH_SPEC_I: begin
            if (low[31]) begin
               pending_text.push_back(CH_MINUS);
               push_number({32'd0, magnitude}, 10, 1'b0);
            end else begin
               push_number({32'd0, low}, 10, 1'b0);
            end
         end
         CH_SPEC_U:  push_number({32'd0, low}, 10, 1'b0);
         CH_SPEC_X:  push_number({32'd0, low}, 16, 1'b0);
         CH_SPEC_UX: push_number({32'd0, low}, 16, 1'b1);
         CH_SPEC_P: begin
            pending_text.push_back(CH_ZERO);
            pending_text.push_back(CH_LOWER_X);
            push_number(arg, 16, 1'b0);
         end
         default: ;
      endcase
   endfunction

   // Advances the formatter state for one accepted transaction and queues the
   // characters it produces. Returns 0 when the transaction is ignored.
   function automatic bit format_item(input req_type item);
      bit      taken;
      rsp_type one_char;
      taken = 1'b1;
      pending_text.delete();
      case (item.kind)
         KIND_FORMAT: begin
            if (parse_state == MODE_IDLE) begin
               if (item.byte_in == CH_NUL) begin
                  char_total = '0;
               end else if (item.byte_in == CH_PERCENT) begin
                  parse_state = MODE_ARMED;
               end else begin
                  pending_text.push_back(item.byte_in);
               end
            end else if (parse_state == MODE_ARMED) begin
               parse_state = MODE_IDLE;
               case (item.byte_in)
                  CH_NUL:     char_total = '0;
                  CH_PERCENT: pending_text.push_back(CH_PERCENT);
                  CH_SPEC_S:  parse_state = MODE_STRING;
                  CH_SPEC_C, CH_SPEC_D, CH_SPEC_I, CH_SPEC_U, CH_SPEC_X, CH_SPEC_UX,
                  CH_SPEC_P: begin
                     pending_conv = item.byte_in;
                     parse_state = MODE_WAIT_ARG;
                  end
                  default: ;
               endcase
            end else begin
               taken = 1'b0;
            end
         end
         KIND_ARG: begin
            if (parse_state == MODE_WAIT_ARG) begin
               render_arg(item.arg_value);
               pending_conv = CH_NUL;
               parse_state = MODE_IDLE;
            end else begin
               taken = 1'b0;
            end
         end
         KIND_STRING: begin
            if (parse_state != MODE_STRING) begin
               taken = 1'b0;
            end else if (item.null_string) begin
               for (int i = 0; i < 6; i++) pending_text.push_back(NULL_TEXT[47 - 8*i -: 8]);
               parse_state = MODE_IDLE;
            end else if (item.byte_in == CH_NUL) begin
               parse_state = MODE_IDLE;
            end else begin
               pending_text.push_back(item.byte_in);
            end
         end
         default: taken = 1'b0;
      endcase
      foreach (pending_text[i]) begin
         if (char_total != COUNT_MAX) char_total++;
         one_char.char_out = pending_text[i];
         one_char.last_char = (i == pending_text.size() - 1);
         one_char.emitted_count = char_total;
         expected_chars.push_back(one_char);
      end
      return taken;
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = item;
      do @(posedge clock); while (!req_ready);
      item_taken = format_item(item);
   endtask

   task automatic send_format(input logic [7:0] b);
      send_item('{kind: KIND_FORMAT, byte_in: b, arg_value: rand64(),
                  null_string: 1'($urandom_range(0, 1))});
   endtask

   task automatic send_arg(input logic [63:0] value);
      send_item('{kind: KIND_ARG, byte_in: 8'($urandom), arg_value: value,
                  null_string: 1'($urandom_range(0, 1))});
   endtask

   task automatic send_string(input logic [7:0] b, input bit is_null);
      send_item('{kind: KIND_STRING, byte_in: b, arg_value: rand64(), null_string: is_null});
   endtask

   task automatic send_noise();
      send_item('{kind: 2'($urandom_range(0, 3)), byte_in: 8'($urandom),
                  arg_value: rand64(), null_string: 1'($urandom_range(0, 1))});
   endtask

   task automatic send_conversion(input logic [7:0] spec, input logic [63:0] value);
      send_format(CH_PERCENT);
      send_format(spec);
      send_arg(value);
   endtask

   task automatic test_plain_text();
      send_format("A");
      send_format(8'hFF);
      send_format(8'h01);
      send_format(CH_NUL);
      send_format(8'h7F);
   endtask

   task automatic test_percent_cases();
      send_format(CH_PERCENT);
      send_format(CH_PERCENT);
      send_format(CH_PERCENT);
      send_format("q");
      send_format(CH_PERCENT);
      send_format(CH_NUL);
   endtask

   task automatic test_conversions();
      send_conversion(CH_SPEC_C, 64'hFFFF_FFFF_FFFF_FF5A);
      send_conversion(CH_SPEC_D, 64'h1234_5678_8000_0000);
      send_conversion(CH_SPEC_I, 64'h0000_0000_7FFF_FFFF);
      send_conversion(CH_SPEC_U, 64'hFFFF_FFFF_FFFF_FFFF);
      send_conversion(CH_SPEC_X, 64'hFFFF_FFFF_0000_0000);
      send_conversion(CH_SPEC_UX, 64'h0000_0000_DEAD_BEEF);
      send_conversion(CH_SPEC_P, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_strings();
      send_format(CH_PERCENT);
      send_format(CH_SPEC_S);
      send_string("o", 1'b0);
      send_string(8'hFF, 1'b0);
      send_string(CH_NUL, 1'b0);
      send_format(CH_PERCENT);
      send_format(CH_SPEC_S);
      send_string(CH_NUL, 1'b1);
   endtask

   task automatic test_out_of_turn();
      send_arg(rand64());
      send_string("z", 1'b0);
      send_item('{kind: KIND_UNUSED, byte_in: "A", arg_value: rand64(), null_string: 1'b1});
      send_format(CH_PERCENT);
      send_format(CH_SPEC_D);
      send_format("A");
      send_string("z", 1'b0);
      send_arg(64'd0);
   endtask

   // The receiver stops for a long stretch while long pointer conversions keep
   // coming, so the block backs up and holds off its input.
   task automatic test_output_stall();
      idle_on = 1'b0;
      hold_request = 1'b1;
      repeat (6) send_conversion(CH_SPEC_P, 64'hFFFF_FFFF_FFFF_FFFF ^ {32'd0, $urandom});
      idle_on = 1'b1;
   endtask

   function automatic logic [63:0] pick_arg();
      case ($urandom_range(0, 4))
         0:       return {$urandom, 32'h8000_0000};
         1:       return {$urandom, 32'($urandom_range(0, 9))};
         2:       return {$urandom, $urandom | 32'h8000_0000};
         3:       return 64'($urandom_range(0, 255));
         default: return rand64();
      endcase
   endfunction

   function automatic logic [7:0] pick_spec();
      case ($urandom_range(0, 8))
         0:       return CH_SPEC_C;
         1:       return CH_SPEC_D;
         2:       return CH_SPEC_I;
         3:       return CH_SPEC_U;
         4:       return CH_SPEC_X;
         5:       return CH_SPEC_UX;
         6:       return CH_SPEC_P;
         7:       return CH_SPEC_S;
         default: return CH_PERCENT;
      endcase
   endfunction

   // Mostly well-formed format text driven by the current parse state, with
   // some random transactions mixed in.
   task automatic test_random_formats();
      int taken_items;
      int r;
      taken_items = 0;
      while (taken_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (taken_items % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (r < 10) begin
            send_noise();
         end else begin
            case (parse_state)
               MODE_IDLE: begin
                  if (r < 16) send_format(CH_NUL);
                  else if (r < 60) send_format(8'($urandom_range(1, 255)));
                  else send_format(CH_PERCENT);
               end
               MODE_ARMED: begin
                  if (r < 85) send_format(pick_spec());
                  else if (r < 93) send_format(8'($urandom));
                  else send_format(CH_NUL);
               end
               MODE_WAIT_ARG: send_arg(pick_arg());
               default: begin
                  if (r < 75) send_string(8'($urandom_range(1, 255)), 1'b0);
                  else if (r < 90) send_string(CH_NUL, 1'b0);
                  else send_string(8'($urandom), 1'b1);
               end
            endcase
         end
         if (item_taken) taken_items++;
      end
      idle_on = 1'b1;
   endtask

   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         if (stall == 0) stall = pick_gap();
         if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_chars
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $error("char_out expected none actual %h", rsp_data.char_out);
            mismatches++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.char_out !== want.char_out) begin
               $error("char_out expected %h actual %h", want.char_out, rsp_data.char_out);
               mismatches++;
            end
            if (rsp_data.last_char !== want.last_char) begin
               $error("last_char expected %b actual %b", want.last_char, rsp_data.last_char);
               mismatches++;
            end
            if (rsp_data.emitted_count !== want.emitted_count) begin
               $error("emitted_count expected %0d actual %0d", want.emitted_count,
                      rsp_data.emitted_count);
               mismatches++;
            end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_plain_text();
      test_percent_cases();
      test_conversions();
      test_strings();
      test_out_of_turn();
      test_output_stall();
      test_random_formats();

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
